/* hw/rtl/rlsp_pkg.sv */
// ----------------------------------------------------------------------------
// rlsp_pkg
// Shared types and constants for the radius limited shortest path engine.
// ----------------------------------------------------------------------------
`default_nettype none

package rlsp_pkg;

  localparam int DIST_W   = 26;   // 18.8 unsigned distance
  localparam int VID_W    = 10;   // vertex index on the ports
  localparam int WIN_W    = 16;   // edge weight on the port
  localparam int CNT_W    = 11;   // count limit / emitted count
  localparam int CMD_W    = 2;
  localparam int STAT_W   = 2;

  localparam int NUM_VERTICES_DEF = 1024;
  localparam int MAX_DEGREE_DEF   = 16;
  localparam int WEIGHT_BITS_DEF  = 16;

  localparam logic [DIST_W-1:0] DIST_ALL_ONES = {DIST_W{1'b1}};

  typedef enum logic [CMD_W-1:0] {
    CMD_CLEAR = 2'd0,
    CMD_ADD   = 2'd1,
    CMD_START = 2'd2,
    CMD_STEP  = 2'd3
  } rlsp_cmd_t;

  typedef enum logic [STAT_W-1:0] {
    ST_ACCEPTED = 2'd0,
    ST_EMITTED  = 2'd1,
    ST_FINISHED = 2'd2,
    ST_FULL     = 2'd3
  } rlsp_status_t;

  // Result of the shared add/compare unit
  typedef struct packed {
    logic [DIST_W-1:0] sum;    // a + w, saturated
    logic              lt_b;   // sum < b
    logic              lt_c;   // sum < c
  } rlsp_alu_res_t;

endpackage

`default_nettype wire

/* hw/rtl/rlsp_alu.sv */
// ----------------------------------------------------------------------------
// rlsp_alu
// Shared saturating adder with two less-than compares.
// ----------------------------------------------------------------------------
`default_nettype none

module rlsp_alu #(
  parameter int WEIGHT_BITS = rlsp_pkg::WEIGHT_BITS_DEF
) (
  input  logic [rlsp_pkg::DIST_W-1:0] a,
  input  logic [WEIGHT_BITS-1:0]      w,
  input  logic [rlsp_pkg::DIST_W-1:0] b,
  input  logic [rlsp_pkg::DIST_W-1:0] c,
  output rlsp_pkg::rlsp_alu_res_t     res
);
  import rlsp_pkg::*;

  localparam int SUM_W = ((WEIGHT_BITS > DIST_W) ? WEIGHT_BITS : DIST_W) + 1;

  logic [SUM_W-1:0]  sum_full;
  logic [DIST_W-1:0] sat;

  assign sum_full = SUM_W'(a) + SUM_W'(w);
  assign sat      = (sum_full > SUM_W'(DIST_ALL_ONES)) ? DIST_ALL_ONES
                                                       : sum_full[DIST_W-1:0];

  assign res.sum  = sat;
  assign res.lt_b = (sat < b);
  assign res.lt_c = (sat < c);

endmodule

`default_nettype wire

/* hw/rtl/radius_limited_shortest_path_top.sv */
// ----------------------------------------------------------------------------
// radius_limited_shortest_path_top
// Dijkstra engine over a stored directed graph with a radius bound.
// ----------------------------------------------------------------------------
// Usage:
//   Request channel in_*: valid/stall. A request is taken when in_valid is
//   high and in_stall low. in_stall is high whenever a request is in work,
//   one request is processed at a time.
//   Result channel out_*: one result per request, held in an output
//   register until out_stall is low. The next request may be taken while
//   a finished result still waits there.
//   Work per request:
//     clear graph : degree table sweep, one entry a cycle
//     add edge    : degree read, duplicate walk over the slots
//     start query : vertex state sweep
//     step query  : min scan one vertex a cycle through the shared compare
//                   unit, then edge relaxation on the memory ports
//   Reset: synchronous, active low. After reset the degree table is swept
//   to zero; no request is taken during the sweep.
//   A stalled receiver only holds the result; work on the next request
//   continues until its own result needs the output register.
// ----------------------------------------------------------------------------
`default_nettype none

module radius_limited_shortest_path_top #(
  parameter int NUM_VERTICES = rlsp_pkg::NUM_VERTICES_DEF,
  parameter int MAX_DEGREE   = rlsp_pkg::MAX_DEGREE_DEF,
  parameter int WEIGHT_BITS  = rlsp_pkg::WEIGHT_BITS_DEF
) (
  input  logic                        clk,
  input  logic                        rst_n,
  input  logic                        in_valid,
  output logic                        in_stall,
  input  logic [rlsp_pkg::CMD_W-1:0]  in_cmd,
  input  logic [rlsp_pkg::VID_W-1:0]  in_from_vertex,
  input  logic [rlsp_pkg::VID_W-1:0]  in_to_vertex,
  input  logic [rlsp_pkg::WIN_W-1:0]  in_edge_weight,
  input  logic [rlsp_pkg::DIST_W-1:0] in_radius_limit,
  input  logic [rlsp_pkg::CNT_W-1:0]  in_count_limit,
  output logic                        out_valid,
  input  logic                        out_stall,
  output logic [rlsp_pkg::STAT_W-1:0] out_status,
  output logic [rlsp_pkg::VID_W-1:0]  out_vertex_id,
  output logic [rlsp_pkg::DIST_W-1:0] out_path_distance,
  output logic [rlsp_pkg::VID_W-1:0]  out_parent_vertex
);
  import rlsp_pkg::*;

  localparam int VW   = (NUM_VERTICES > 1) ? $clog2(NUM_VERTICES) : 1;
  localparam int SW   = (MAX_DEGREE > 1) ? $clog2(MAX_DEGREE) : 1;
  localparam int DGW  = $clog2(MAX_DEGREE + 1);
  localparam int EW   = VW + WEIGHT_BITS;          // edge word: dest, weight
  localparam int VS_W = 1 + VW + DIST_W;           // settled, parent, dist
  localparam int EDEPTH = NUM_VERTICES * (2 ** SW);
  localparam logic [VW-1:0]  VLAST = VW'(NUM_VERTICES - 1);
  localparam logic [DGW-1:0] DMAX  = DGW'(MAX_DEGREE);

  typedef enum logic [12:0] {
    S_CLR    = 13'b0000000000001,  // degree sweep
    S_IDLE   = 13'b0000000000010,
    S_DONE   = 13'b0000000000100,  // result waits for output register
    S_AE_DEG = 13'b0000000001000,
    S_AE_LAT = 13'b0000000010000,
    S_AE_SC  = 13'b0000000100000,
    S_AE_CMP = 13'b0000001000000,
    S_SQ_CLR = 13'b0000010000000,
    S_SC     = 13'b0000100000000,
    S_SC_END = 13'b0001000000000,
    S_RX_DEG = 13'b0010000000000,
    S_RX_E   = 13'b0100000000000,
    S_RX_C   = 13'b1000000000000
  } state_t;

  // memories
  logic [DGW-1:0]  deg_mem [NUM_VERTICES];
  logic [EW-1:0]   edge_mem [EDEPTH];
  logic [VS_W-1:0] vs_mem [NUM_VERTICES];

  logic [DGW-1:0]  deg_q;
  logic [EW-1:0]   edge_q;
  logic [VS_W-1:0] vs_q;

  logic            deg_we, edge_we, vs_we;
  logic [VW-1:0]   deg_waddr, deg_raddr, vs_waddr, vs_raddr;
  logic [DGW-1:0]  deg_wdata;
  logic [VW+SW-1:0] edge_waddr, edge_raddr;
  logic [EW-1:0]   edge_wdata;
  logic [VS_W-1:0] vs_wdata;

  // registers
  state_t            state_r, state_nxt;
  logic [VW-1:0]     cnt_r, cnt_nxt;
  logic              clr_reply_r, clr_reply_nxt;
  logic              running_r, running_nxt;
  logic [DIST_W-1:0] radius_r, radius_nxt;
  logic [CNT_W-1:0]  lim_r, lim_nxt;
  logic [CNT_W-1:0]  emitted_r, emitted_nxt;
  logic              src_ok_r, src_ok_nxt;
  logic [VW-1:0]     fv_r, fv_nxt;
  logic [VW-1:0]     tv_r, tv_nxt;
  logic [WEIGHT_BITS-1:0] wt_r, wt_nxt;
  logic [DGW-1:0]    deg_r, deg_nxt;
  logic [DGW-1:0]    slot_r, slot_nxt;
  logic              found_r, found_nxt;
  logic [VW-1:0]     best_r, best_nxt;
  logic [DIST_W-1:0] best_d_r, best_d_nxt;
  logic [VW-1:0]     best_par_r, best_par_nxt;
  logic              pv_r, pv_nxt;
  logic [VW-1:0]     pidx_r, pidx_nxt;
  logic [WEIGHT_BITS-1:0] ew_r, ew_nxt;
  rlsp_status_t      res_st_r, res_st_nxt;
  logic              out_valid_r, out_valid_nxt;
  logic [STAT_W-1:0] out_status_r, out_status_nxt;
  logic [VID_W-1:0]  out_vid_r, out_vid_nxt;
  logic [DIST_W-1:0] out_dist_r, out_dist_nxt;
  logic [VID_W-1:0]  out_par_r, out_par_nxt;

  // vertex state word fields
  logic              vq_settled;
  logic [VW-1:0]     vq_parent;
  logic [DIST_W-1:0] vq_dist;
  logic [VW-1:0]     eq_dest;
  logic [WEIGHT_BITS-1:0] eq_wt;

  assign vq_settled = vs_q[VS_W-1];
  assign vq_parent  = vs_q[DIST_W +: VW];
  assign vq_dist    = vs_q[DIST_W-1:0];
  assign eq_dest    = edge_q[WEIGHT_BITS +: VW];
  assign eq_wt      = edge_q[WEIGHT_BITS-1:0];

  // shared add/compare unit
  logic [DIST_W-1:0]      alu_a, alu_b;
  logic [WEIGHT_BITS-1:0] alu_w;
  rlsp_alu_res_t          alu_res;

  rlsp_alu #(.WEIGHT_BITS(WEIGHT_BITS)) u_alu (
    .a   (alu_a),
    .w   (alu_w),
    .b   (alu_b),
    .c   (radius_r),
    .res (alu_res)
  );

  logic in_acc;
  logic fv_ok, tv_ok;
  logic scan_hit;
  logic out_free;

  assign in_stall = (state_r != S_IDLE);
  assign in_acc   = in_valid && (state_r == S_IDLE);
  assign fv_ok    = (32'(in_from_vertex) < NUM_VERTICES);
  assign tv_ok    = (32'(in_to_vertex) < NUM_VERTICES);
  assign out_free = !out_valid_r || !out_stall;

  // scan candidate: reached, unsettled, and strictly closer than the best
  assign scan_hit = pv_r && ((state_r == S_SC) || (state_r == S_SC_END)) &&
                    !vq_settled && (vq_dist != DIST_ALL_ONES) &&
                    (!found_r || alu_res.lt_b);

  always_comb begin
    if (state_r == S_RX_C) begin
      alu_a = best_d_r;
      alu_w = ew_r;
      alu_b = vq_dist;
    end else begin
      alu_a = vq_dist;
      alu_w = '0;
      alu_b = best_d_r;
    end
  end

  // memory address selection
  assign deg_raddr  = (state_r == S_RX_DEG) ? best_r : fv_r;
  assign edge_raddr = (state_r == S_RX_E) ? {best_r, slot_r[SW-1:0]}
                                          : {fv_r, slot_r[SW-1:0]};
  assign vs_raddr   = (state_r == S_RX_E) ? eq_dest : cnt_r;

  always_comb begin
    state_nxt     = state_r;
    cnt_nxt       = cnt_r;
    clr_reply_nxt = clr_reply_r;
    running_nxt   = running_r;
    radius_nxt    = radius_r;
    lim_nxt       = lim_r;
    emitted_nxt   = emitted_r;
    src_ok_nxt    = src_ok_r;
    fv_nxt        = fv_r;
    tv_nxt        = tv_r;
    wt_nxt        = wt_r;
    deg_nxt       = deg_r;
    slot_nxt      = slot_r;
    found_nxt     = found_r;
    best_nxt      = best_r;
    best_d_nxt    = best_d_r;
    best_par_nxt  = best_par_r;
    pv_nxt        = 1'b0;
    pidx_nxt      = pidx_r;
    ew_nxt        = ew_r;
    res_st_nxt    = res_st_r;
    out_valid_nxt = out_valid_r;
    out_status_nxt = out_status_r;
    out_vid_nxt   = out_vid_r;
    out_dist_nxt  = out_dist_r;
    out_par_nxt   = out_par_r;

    deg_we     = 1'b0;
    deg_waddr  = cnt_r;
    deg_wdata  = '0;
    edge_we    = 1'b0;
    edge_waddr = {fv_r, deg_r[SW-1:0]};
    edge_wdata = {tv_r, wt_r};
    vs_we      = 1'b0;
    vs_waddr   = cnt_r;
    vs_wdata   = {1'b0, cnt_r,
                  (src_ok_r && cnt_r == fv_r) ? DIST_W'(0) : DIST_ALL_ONES};

    if (out_valid_r && !out_stall) begin
      out_valid_nxt = 1'b0;
    end

    // scan compare runs whenever a scan read is in flight
    if (scan_hit) begin
      found_nxt    = 1'b1;
      best_nxt     = pidx_r;
      best_d_nxt   = vq_dist;
      best_par_nxt = vq_parent;
    end

    case (state_r)
      S_CLR: begin
        deg_we  = 1'b1;
        cnt_nxt = cnt_r + 1'b1;
        if (cnt_r == VLAST) begin
          cnt_nxt    = '0;
          res_st_nxt = ST_ACCEPTED;
          state_nxt  = clr_reply_r ? S_DONE : S_IDLE;
        end
      end
      S_IDLE: begin
        if (in_acc) begin
          fv_nxt   = VW'(in_from_vertex);
          tv_nxt   = VW'(in_to_vertex);
          wt_nxt   = WEIGHT_BITS'(in_edge_weight);
          cnt_nxt  = '0;
          slot_nxt = '0;
          case (rlsp_cmd_t'(in_cmd))
            CMD_CLEAR: begin
              running_nxt   = 1'b0;
              clr_reply_nxt = 1'b1;
              state_nxt     = S_CLR;
            end
            CMD_ADD: begin
              res_st_nxt = ST_ACCEPTED;
              state_nxt  = (fv_ok && tv_ok) ? S_AE_DEG : S_DONE;
            end
            CMD_START: begin
              radius_nxt  = in_radius_limit;
              lim_nxt     = in_count_limit;
              emitted_nxt = '0;
              running_nxt = 1'b1;
              src_ok_nxt  = fv_ok;
              state_nxt   = S_SQ_CLR;
            end
            CMD_STEP: begin
              if (running_r && (emitted_r < lim_r)) begin
                found_nxt = 1'b0;
                state_nxt = S_SC;
              end else begin
                running_nxt = 1'b0;
                res_st_nxt  = ST_FINISHED;
                state_nxt   = S_DONE;
              end
            end
            default: state_nxt = S_DONE;
          endcase
        end
      end
      S_DONE: begin
        if (out_free) begin
          out_valid_nxt  = 1'b1;
          out_status_nxt = res_st_r;
          if (res_st_r == ST_EMITTED) begin
            out_vid_nxt  = VID_W'(best_r);
            out_dist_nxt = best_d_r;
            out_par_nxt  = VID_W'(best_par_r);
          end else begin
            out_vid_nxt  = '0;
            out_dist_nxt = '0;
            out_par_nxt  = '0;
          end
          state_nxt = S_IDLE;
        end
      end
      // add edge: degree read, then walk the stored slots for a duplicate
      S_AE_DEG: state_nxt = S_AE_LAT;
      S_AE_LAT: begin
        deg_nxt   = deg_q;
        state_nxt = S_AE_SC;
      end
      S_AE_SC: begin
        if (slot_r < deg_r) begin
          state_nxt = S_AE_CMP;
        end else if (deg_r >= DMAX) begin
          res_st_nxt = ST_FULL;
          state_nxt  = S_DONE;
        end else begin
          edge_we    = 1'b1;
          deg_we     = 1'b1;
          deg_waddr  = fv_r;
          deg_wdata  = deg_r + 1'b1;
          res_st_nxt = ST_ACCEPTED;
          state_nxt  = S_DONE;
        end
      end
      S_AE_CMP: begin
        if (eq_dest == tv_r) begin
          res_st_nxt = ST_ACCEPTED;
          state_nxt  = S_DONE;
        end else begin
          slot_nxt  = slot_r + 1'b1;
          state_nxt = S_AE_SC;
        end
      end
      // start query: reinit every vertex word
      S_SQ_CLR: begin
        vs_we   = 1'b1;
        cnt_nxt = cnt_r + 1'b1;
        if (cnt_r == VLAST) begin
          cnt_nxt    = '0;
          res_st_nxt = ST_ACCEPTED;
          state_nxt  = S_DONE;
        end
      end
      // min scan, one read issued per cycle, compared in the cycle after
      S_SC: begin
        pv_nxt   = 1'b1;
        pidx_nxt = cnt_r;
        cnt_nxt  = cnt_r + 1'b1;
        if (cnt_r == VLAST) begin
          cnt_nxt   = '0;
          state_nxt = S_SC_END;
        end
      end
      S_SC_END: begin
        if (found_nxt) begin
          state_nxt = S_RX_DEG;
        end else begin
          running_nxt = 1'b0;
          res_st_nxt  = ST_FINISHED;
          state_nxt   = S_DONE;
        end
      end
      // settle the winner, fetch its degree
      S_RX_DEG: begin
        vs_we       = 1'b1;
        vs_waddr    = best_r;
        vs_wdata    = {1'b1, best_par_r, best_d_r};
        emitted_nxt = emitted_r + 1'b1;
        slot_nxt    = '0;
        deg_nxt     = '0;
        state_nxt   = S_AE_LAT;
        res_st_nxt  = ST_EMITTED;
        state_nxt   = S_RX_E;
      end
      // relaxation loop: edge read, vertex read, add/compare/write
      S_RX_E: begin
        // first pass through here holds the degree read of the winner
        if (slot_r == '0 && !pv_r) begin
          deg_nxt = deg_q;
        end
        if (slot_r < ((slot_r == '0 && !pv_r) ? deg_q : deg_r)) begin
          pv_nxt    = 1'b0;
          state_nxt = S_RX_C;
        end else begin
          state_nxt = S_DONE;
        end
      end
      S_RX_C: begin
        // edge word is valid now; latch it and wait for the vertex read
        if (!pv_r) begin
          ew_nxt   = eq_wt;
          pidx_nxt = eq_dest;
          pv_nxt   = 1'b1;
        end else begin
          if (alu_res.lt_b && alu_res.lt_c) begin
            vs_we    = 1'b1;
            vs_waddr = pidx_r;
            vs_wdata = {vq_settled, best_r, alu_res.sum};
          end
          slot_nxt  = slot_r + 1'b1;
          pv_nxt    = 1'b1;
          state_nxt = S_RX_E;
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  // in the relaxation loop pv marks "degree already latched" in S_RX_E and
  // "vertex read in flight" in S_RX_C; the scan compare is gated to S_SC*
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_CLR;
      cnt_r       <= '0;
      clr_reply_r <= 1'b0;
      running_r   <= 1'b0;
      radius_r    <= '0;
      lim_r       <= '0;
      emitted_r   <= '0;
      src_ok_r    <= 1'b0;
      found_r     <= 1'b0;
      pv_r        <= 1'b0;
      slot_r      <= '0;
      out_valid_r <= 1'b0;
      res_st_r    <= ST_ACCEPTED;
    end else begin
      state_r     <= state_nxt;
      cnt_r       <= cnt_nxt;
      clr_reply_r <= clr_reply_nxt;
      running_r   <= running_nxt;
      radius_r    <= radius_nxt;
      lim_r       <= lim_nxt;
      emitted_r   <= emitted_nxt;
      src_ok_r    <= src_ok_nxt;
      found_r     <= found_nxt;
      pv_r        <= pv_nxt;
      slot_r      <= slot_nxt;
      out_valid_r <= out_valid_nxt;
      res_st_r    <= res_st_nxt;
    end
  end

  always_ff @(posedge clk) begin
    fv_r         <= fv_nxt;
    tv_r         <= tv_nxt;
    wt_r         <= wt_nxt;
    deg_r        <= deg_nxt;
    best_r       <= best_nxt;
    best_d_r     <= best_d_nxt;
    best_par_r   <= best_par_nxt;
    pidx_r       <= pidx_nxt;
    ew_r         <= ew_nxt;
    out_status_r <= out_status_nxt;
    out_vid_r    <= out_vid_nxt;
    out_dist_r   <= out_dist_nxt;
    out_par_r    <= out_par_nxt;
  end

  // memories: one write, one registered read each
  always_ff @(posedge clk) begin
    if (deg_we) begin
      deg_mem[deg_waddr] <= deg_wdata;
    end
    deg_q <= deg_mem[deg_raddr];
  end

  always_ff @(posedge clk) begin
    if (edge_we) begin
      edge_mem[edge_waddr] <= edge_wdata;
    end
    edge_q <= edge_mem[edge_raddr];
  end

  always_ff @(posedge clk) begin
    if (vs_we) begin
      vs_mem[vs_waddr] <= vs_wdata;
    end
    vs_q <= vs_mem[(state_r == S_RX_C) ? eq_dest : vs_raddr];
  end

  assign out_valid         = out_valid_r;
  assign out_status        = out_status_r;
  assign out_vertex_id     = out_vid_r;
  assign out_path_distance = out_dist_r;
  assign out_parent_vertex = out_par_r;

endmodule

`default_nettype wire

/* dv/radius_limited_shortest_path_top_tb.sv */
// ----------------------------------------------------------------------------
// radius_limited_shortest_path_top_tb
// Drives graph build / query requests into the shortest path engine and
// checks every result against a behavioral Dijkstra model or the row's exp_*.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module radius_limited_shortest_path_top_tb;
  import rlsp_pkg::*;

  localparam int NV        = NUM_VERTICES_DEF;
  localparam int MAXDEG    = MAX_DEGREE_DEF;
  localparam int RAND_REQS = 250;
  localparam int CYCLE_CAP = 3000000;

  // one request row; exp_* is used only where chk is set
  typedef struct {
    rlsp_cmd_t         cmd;
    logic [VID_W-1:0]  fv;
    logic [VID_W-1:0]  tv;
    logic [WIN_W-1:0]  w;
    logic [DIST_W-1:0] rad;
    logic [CNT_W-1:0]  cl;
    bit                chk;
    rlsp_status_t      exp_st;
    logic [VID_W-1:0]  exp_v;
    logic [DIST_W-1:0] exp_d;
    logic [VID_W-1:0]  exp_p;
  } req_t;

  typedef struct {
    rlsp_status_t      st;
    logic [VID_W-1:0]  v;
    logic [DIST_W-1:0] d;
    logic [VID_W-1:0]  p;
  } result_t;

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic in_valid = 1'b0;
  logic in_stall;
  logic [CMD_W-1:0]  in_cmd = '0;
  logic [VID_W-1:0]  in_from_vertex = '0;
  logic [VID_W-1:0]  in_to_vertex = '0;
  logic [WIN_W-1:0]  in_edge_weight = '0;
  logic [DIST_W-1:0] in_radius_limit = '0;
  logic [CNT_W-1:0]  in_count_limit = '0;
  logic out_valid;
  logic out_stall = 1'b1;
  logic [STAT_W-1:0] out_status;
  logic [VID_W-1:0]  out_vertex_id;
  logic [DIST_W-1:0] out_path_distance;
  logic [VID_W-1:0]  out_parent_vertex;

  always #5 clk = ~clk;

  radius_limited_shortest_path_top uut (
    .clk(clk), .rst_n(rst_n),
    .in_valid(in_valid), .in_stall(in_stall),
    .in_cmd(in_cmd), .in_from_vertex(in_from_vertex), .in_to_vertex(in_to_vertex),
    .in_edge_weight(in_edge_weight), .in_radius_limit(in_radius_limit),
    .in_count_limit(in_count_limit),
    .out_valid(out_valid), .out_stall(out_stall),
    .out_status(out_status), .out_vertex_id(out_vertex_id),
    .out_path_distance(out_path_distance), .out_parent_vertex(out_parent_vertex)
  );

  // --------------------------------------------------------------------------
  // Graph and query state mirrored from the engine
  // --------------------------------------------------------------------------
  logic [VID_W-1:0]  edge_dst [NV][MAXDEG];
  logic [WIN_W-1:0]  edge_len [NV][MAXDEG];
  int                out_degree [NV];
  logic [DIST_W-1:0] best_dist [NV];
  logic [VID_W-1:0]  via_vertex [NV];
  bit                done_flag [NV];
  int                settled_cnt;
  logic [DIST_W-1:0] q_radius;
  int                q_count_cap;
  bit                q_active;

  result_t expected_results[$];
  int      mismatches = 0;
  int      cycle_cnt = 0;

  function automatic void add_expected(result_t e);
    expected_results.insert(expected_results.size(), e);
  endfunction

  function automatic void clear_paths();
    for (int i = 0; i < NV; i++) begin
      best_dist[i]  = DIST_ALL_ONES;
      via_vertex[i] = VID_W'(i);
      done_flag[i]  = 1'b0;
    end
  endfunction

  // Dijkstra engine behavior for one request
  function automatic result_t dijkstra_response(req_t r);
    result_t res;
    int      best;
    int      dg;
    bit      dup;
    logic [DIST_W:0]   sum;
    logic [DIST_W-1:0] nd;
    res = '{ST_ACCEPTED, '0, '0, '0};
    best = -1;
    case (r.cmd)
      CMD_CLEAR: begin
        for (int i = 0; i < NV; i++) out_degree[i] = 0;
        q_active = 1'b0;
      end
      CMD_ADD: begin
        dg = out_degree[r.fv];
        dup = 1'b0;
        for (int i = 0; i < dg; i++)
          if (edge_dst[r.fv][i] == r.tv) dup = 1'b1;
        // duplicate check wins over the full check
        if (!dup) begin
          if (dg >= MAXDEG) begin
            res.st = ST_FULL;
          end else begin
            edge_dst[r.fv][dg] = r.tv;
            edge_len[r.fv][dg] = r.w;
            out_degree[r.fv] = dg + 1;
          end
        end
      end
      CMD_START: begin
        clear_paths();
        best_dist[r.fv] = '0;
        q_radius = r.rad;
        q_count_cap = r.cl;
        settled_cnt = 0;
        q_active = 1'b1;
      end
      default: begin
        res.st = ST_FINISHED;
        if (q_active && settled_cnt < q_count_cap) begin
          // strict < keeps the lowest index on ties
          for (int i = 0; i < NV; i++)
            if (!done_flag[i] && best_dist[i] != DIST_ALL_ONES &&
                (best < 0 || best_dist[i] < best_dist[best]))
              best = i;
        end
        if (best >= 0) begin
          done_flag[best] = 1'b1;
          settled_cnt++;
          res = '{ST_EMITTED, VID_W'(best), best_dist[best], via_vertex[best]};
          for (int i = 0; i < out_degree[best]; i++) begin
            sum = {1'b0, best_dist[best]} + edge_len[best][i];
            nd  = sum[DIST_W] ? DIST_ALL_ONES : sum[DIST_W-1:0];
            if (nd < best_dist[edge_dst[best][i]] && nd < q_radius) begin
              best_dist[edge_dst[best][i]]  = nd;
              via_vertex[edge_dst[best][i]] = VID_W'(best);
            end
          end
        end else begin
          q_active = 1'b0;
        end
      end
    endcase
    return res;
  endfunction

  // mostly back to back, now and then a long hole
  function automatic int gap_len();
    int r;
    r = $urandom_range(99);
    if (r < 60) return 0;
    if (r < 94) return $urandom_range(3, 1);
    return $urandom_range(60, 20);
  endfunction

  // Called at a falling edge; returns at a falling edge after acceptance.
  task automatic send_request(req_t r);
    int gap;
    result_t pred;
    in_valid        = 1'b1;
    in_cmd          = r.cmd;
    in_from_vertex  = r.fv;
    in_to_vertex    = r.tv;
    in_edge_weight  = r.w;
    in_radius_limit = r.rad;
    in_count_limit  = r.cl;
    do @(posedge clk); while (in_stall !== 1'b0);
    pred = dijkstra_response(r);
    if (r.chk) pred = '{r.exp_st, r.exp_v, r.exp_d, r.exp_p};
    add_expected(pred);
    @(negedge clk);
    gap = gap_len();
    if (gap > 0) begin
      in_valid = 1'b0;
      repeat (gap) @(negedge clk);
    end
  endtask

  function automatic req_t mk(rlsp_cmd_t c, int fv, int tv, int w, int rad, int cl);
    req_t r;
    r = '{c, VID_W'(fv), VID_W'(tv), WIN_W'(w), DIST_W'(rad), CNT_W'(cl),
          1'b0, ST_ACCEPTED, '0, '0, '0};
    return r;
  endfunction

  function automatic req_t mkx(req_t r, rlsp_status_t st, int v, int d, int p);
    r.chk = 1'b1;
    r.exp_st = st;
    r.exp_v = VID_W'(v);
    r.exp_d = DIST_W'(d);
    r.exp_p = VID_W'(p);
    return r;
  endfunction

  // --------------------------------------------------------------------------
  // Result side: random stall, checked at the rising edge
  // --------------------------------------------------------------------------
  int stall_left = 0;
  always @(negedge clk) begin
    if (stall_left > 0) begin
      stall_left <= stall_left - 1;
      out_stall <= 1'b1;
    end else begin
      stall_left <= gap_len();
      out_stall <= 1'b0;
    end
  end

  always @(posedge clk) begin
    result_t e;
    if (rst_n && out_valid && !out_stall) begin
      if (expected_results.size() == 0) begin
        $display("%0t: unexpected result status=%0d v=%0d d=%h p=%0d", $time,
                 out_status, out_vertex_id, out_path_distance, out_parent_vertex);
        mismatches++;
      end else begin
        e = expected_results.pop_front();
        if (out_status !== e.st) begin
          $display("%0t: status exp %0d got %0d", $time, e.st, out_status);
          mismatches++;
        end
        if (out_vertex_id !== e.v) begin
          $display("%0t: vertex_id exp %0d got %0d", $time, e.v, out_vertex_id);
          mismatches++;
        end
        if (out_path_distance !== e.d) begin
          $display("%0t: path_distance exp %h got %h", $time, e.d, out_path_distance);
          mismatches++;
        end
        if (out_parent_vertex !== e.p) begin
          $display("%0t: parent_vertex exp %0d got %0d", $time, e.p, out_parent_vertex);
          mismatches++;
        end
      end
    end
  end

  // watchdog: the slowest legal run needs only a fraction of this
  always @(posedge clk) begin
    cycle_cnt <= cycle_cnt + 1;
    if (cycle_cnt >= CYCLE_CAP) begin
      $display("radius_limited_shortest_path_top_tb: done, errors");
      $finish;
    end
  end

  // --------------------------------------------------------------------------
  // Stimulus
  // --------------------------------------------------------------------------
  req_t directed[$];

  function automatic void add_row(req_t r);
    directed.insert(directed.size(), r);
  endfunction

  initial begin
    int sent;
    int pool;
    int base;
    int n;
    int r;
    int rad;
    int cl;
    int w;
    req_t q;

    for (int i = 0; i < NV; i++) out_degree[i] = 0;
    clear_paths();
    settled_cnt = 0;
    q_radius = '0;
    q_count_cap = 0;
    q_active = 1'b0;

    // idle step, extreme vertices and weights, duplicate edge, radius 0,
    // count limit 0, then a bounded radius
    add_row(mkx(mk(CMD_STEP, 0, 0, 0, 0, 0), ST_FINISHED, 0, 0, 0));
    add_row(mkx(mk(CMD_CLEAR, 0, 0, 0, 0, 0), ST_ACCEPTED, 0, 0, 0));
    add_row(mkx(mk(CMD_ADD, 0, 1023, 'hffff, 0, 0), ST_ACCEPTED, 0, 0, 0));
    add_row(mkx(mk(CMD_ADD, 0, 1023, 1, 0, 0), ST_ACCEPTED, 0, 0, 0));
    add_row(mkx(mk(CMD_ADD, 1023, 0, 0, 0, 0), ST_ACCEPTED, 0, 0, 0));
    add_row(mkx(mk(CMD_START, 0, 0, 0, 'h3ffffff, 1024),
                ST_ACCEPTED, 0, 0, 0));
    add_row(mkx(mk(CMD_STEP, 0, 0, 0, 0, 0), ST_EMITTED, 0, 0, 0));
    add_row(mkx(mk(CMD_STEP, 0, 0, 0, 0, 0), ST_EMITTED, 1023, 'hffff, 0));
    add_row(mkx(mk(CMD_STEP, 0, 0, 0, 0, 0), ST_FINISHED, 0, 0, 0));
    add_row(mkx(mk(CMD_STEP, 0, 0, 0, 0, 0), ST_FINISHED, 0, 0, 0));
    add_row(mkx(mk(CMD_START, 1023, 0, 0, 0, 2047), ST_ACCEPTED, 0, 0, 0));
    add_row(mkx(mk(CMD_STEP, 0, 0, 0, 0, 0), ST_EMITTED, 1023, 0, 1023));
    add_row(mkx(mk(CMD_STEP, 0, 0, 0, 0, 0), ST_FINISHED, 0, 0, 0));
    add_row(mkx(mk(CMD_START, 0, 0, 0, 'h3ffffff, 0), ST_ACCEPTED, 0, 0, 0));
    add_row(mkx(mk(CMD_STEP, 0, 0, 0, 0, 0), ST_FINISHED, 0, 0, 0));
    add_row(mk(CMD_START, 0, 0, 0, 'h10000, 5));
    add_row(mk(CMD_STEP, 0, 0, 0, 0, 0));
    add_row(mk(CMD_STEP, 0, 0, 0, 0, 0));
    add_row(mk(CMD_STEP, 0, 0, 0, 0, 0));
    // fill one table past capacity, then a duplicate on the full table
    for (int i = 0; i < MAXDEG + 1; i++)
      add_row(mk(CMD_ADD, 2, i + 3, 'h100, 0, 0));
    add_row(mk(CMD_ADD, 2, 3, 'h100, 0, 0));

    repeat (8) @(negedge clk);
    rst_n = 1'b1;

    foreach (directed[i]) send_request(directed[i]);

    // hold off until every directed result is back
    in_valid = 1'b0;
    while (expected_results.size() != 0) @(negedge clk);

    // random phases: build a small graph, query it, step it out
    sent = 0;
    while (sent < RAND_REQS) begin
      if ($urandom_range(9) == 0) begin
        send_request(mk(CMD_CLEAR, $urandom, $urandom, $urandom, $urandom, $urandom));
        sent++;
      end
      pool = $urandom_range(24, 4);
      base = ($urandom_range(3) == 0) ? $urandom_range(NV - pool) : 0;
      n = $urandom_range(20, 3);
      for (int i = 0; i < n; i++) begin
        r = $urandom_range(9);
        w = (r < 3) ? $urandom : (r < 5) ? 'h100 * $urandom_range(3) :
            (r == 5) ? 0 : (r == 6) ? 'hffff : $urandom_range('h800);
        if ($urandom_range(15) == 0)
          q = mk(CMD_ADD, $urandom, $urandom, w, $urandom, $urandom);
        else
          q = mk(CMD_ADD, base + $urandom_range(pool - 1),
                 base + $urandom_range(pool - 1), w, $urandom, $urandom);
        send_request(q);
        sent++;
      end
      // now and then hold off until the engine has drained everything
      if ($urandom_range(3) == 0) begin
        in_valid = 1'b0;
        while (expected_results.size() != 0) @(negedge clk);
      end
      r = $urandom_range(3);
      rad = (r == 0) ? 'h3ffffff : (r == 1) ? $urandom : $urandom_range('h4000);
      r = $urandom_range(4);
      cl = (r == 0) ? $urandom_range(2047) : (r == 1) ? 0 : $urandom_range(pool + 2);
      send_request(mk(CMD_START, base + $urandom_range(pool - 1), $urandom, $urandom,
                      rad, cl));
      sent++;
      n = $urandom_range(pool + 3);
      for (int i = 0; i < n; i++) begin
        if ($urandom_range(7) == 0)
          q = mk(CMD_ADD, base + $urandom_range(pool - 1),
                 base + $urandom_range(pool - 1), $urandom_range('h400), 0, 0);
        else
          q = mk(CMD_STEP, $urandom, $urandom, $urandom, $urandom, $urandom);
        send_request(q);
        sent++;
      end
    end

    in_valid = 1'b0;
    while (expected_results.size() != 0) @(negedge clk);
    repeat (100) @(negedge clk);
    if (mismatches == 0)
      $display("radius_limited_shortest_path_top_tb: done, clean");
    else
      $display("radius_limited_shortest_path_top_tb: done, errors");
    $finish;
  end

endmodule
